>>> design/quaternion_to_rotation_matrix_defines.svh
// Assertion macros used by the quaternion to rotation matrix top level.
`ifndef QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define QRM_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define QRM_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> design/qrm_pkg.sv
// Shared constants for the quaternion to rotation matrix pipeline.
`default_nettype none
package qrm_pkg;
  localparam int unsigned IN_WIDTH_DEF  = 16;
  localparam int unsigned OUT_WIDTH_DEF = 16;
  localparam int unsigned NUM_ENTRIES   = 9;
endpackage
`default_nettype wire

>>> design/qrm_in_if.sv
// Input channel: quaternion beats.
`default_nettype none
interface qrm_in_if import qrm_pkg::*; #(
  parameter int unsigned IN_WIDTH = IN_WIDTH_DEF
);
  logic                       valid;
  logic                       ready;
  logic signed [IN_WIDTH-1:0] scalar_part;
  logic signed [IN_WIDTH-1:0] vec_x;
  logic signed [IN_WIDTH-1:0] vec_y;
  logic signed [IN_WIDTH-1:0] vec_z;

  modport source (output valid, scalar_part, vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, scalar_part, vec_x, vec_y, vec_z, output ready);
endinterface
`default_nettype wire

>>> design/qrm_out_if.sv
// Output channel: rotation matrix beats.
`default_nettype none
interface qrm_out_if import qrm_pkg::*; #(
  parameter int unsigned OUT_WIDTH = OUT_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] m00;
  logic signed [OUT_WIDTH-1:0] m01;
  logic signed [OUT_WIDTH-1:0] m02;
  logic signed [OUT_WIDTH-1:0] m10;
  logic signed [OUT_WIDTH-1:0] m11;
  logic signed [OUT_WIDTH-1:0] m12;
  logic signed [OUT_WIDTH-1:0] m20;
  logic signed [OUT_WIDTH-1:0] m21;
  logic signed [OUT_WIDTH-1:0] m22;
  logic                        zero_norm;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_norm,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_norm,
                  output ready);
endinterface
`default_nettype wire

>>> design/quaternion_to_rotation_matrix.sv
// Top level: quaternion to normalized 3x3 rotation matrix, fully pipelined.
//
//  channel    dir  beat contents
//  in_ch_i    in   scalar_part, vec_x, vec_y, vec_z
//  out_ch_o   out  m00..m22, zero_norm
//
// The stages are products, numerators, then one divider stage per quotient bit
// and a rounding stage; one beat per cycle while the output is not stalled.
// Each stage holds its beat while the stage after it is full and stalled.
// rst_ni clears only the valid bits; no state beyond the pipeline.
`default_nettype none
`include "quaternion_to_rotation_matrix_defines.svh"
module quaternion_to_rotation_matrix import qrm_pkg::*; #(
  parameter int unsigned IN_WIDTH  = IN_WIDTH_DEF,
  parameter int unsigned OUT_WIDTH = OUT_WIDTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  qrm_in_if.sink      in_ch_i,
  qrm_out_if.source   out_ch_o
);
  localparam int unsigned PW    = 2 * IN_WIDTH;
  localparam int unsigned NW    = PW + 1;
  localparam int unsigned NUMW  = PW + 2;
  localparam int unsigned STEPS = OUT_WIDTH - 1;
  localparam int unsigned LS    = STEPS + 2;
  localparam int unsigned NS    = LS + 2;
  localparam logic signed [OUT_WIDTH-1:0] LIMIT = OUT_WIDTH'(1) << (OUT_WIDTH - 2);

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;
  logic [NS-1:1] zero_q;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ch_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ch_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_ch_i.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 0: products
  logic signed [PW-1:0] ww_q, xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ww_q <= in_ch_i.scalar_part * in_ch_i.scalar_part;
      xx_q <= in_ch_i.vec_x * in_ch_i.vec_x;
      yy_q <= in_ch_i.vec_y * in_ch_i.vec_y;
      zz_q <= in_ch_i.vec_z * in_ch_i.vec_z;
      xy_q <= in_ch_i.vec_x * in_ch_i.vec_y;
      xz_q <= in_ch_i.vec_x * in_ch_i.vec_z;
      yz_q <= in_ch_i.vec_y * in_ch_i.vec_z;
      wx_q <= in_ch_i.scalar_part * in_ch_i.vec_x;
      wy_q <= in_ch_i.scalar_part * in_ch_i.vec_y;
      wz_q <= in_ch_i.scalar_part * in_ch_i.vec_z;
    end
  end

  // stage 1: numerators and squared norm
  logic signed [NUMW-1:0] ww_s, xx_s, yy_s, zz_s, xy_s, xz_s, yz_s, wx_s, wy_s, wz_s;
  logic signed [NUMW-1:0] num_d [NUM_ENTRIES];
  logic signed [NUMW-1:0] num_q [NUM_ENTRIES];
  logic signed [NUMW-1:0] n_d;
  logic [NW-1:0]          n_q;

  always_comb begin
    ww_s = NUMW'(ww_q); xx_s = NUMW'(xx_q); yy_s = NUMW'(yy_q); zz_s = NUMW'(zz_q);
    xy_s = NUMW'(xy_q); xz_s = NUMW'(xz_q); yz_s = NUMW'(yz_q);
    wx_s = NUMW'(wx_q); wy_s = NUMW'(wy_q); wz_s = NUMW'(wz_q);
    n_d      = (ww_s + xx_s) + (yy_s + zz_s);
    num_d[0] = (ww_s + xx_s) - (yy_s + zz_s);
    num_d[1] = (xy_s - wz_s) <<< 1;
    num_d[2] = (xz_s + wy_s) <<< 1;
    num_d[3] = (xy_s + wz_s) <<< 1;
    num_d[4] = (ww_s + yy_s) - (xx_s + zz_s);
    num_d[5] = (yz_s - wx_s) <<< 1;
    num_d[6] = (xz_s - wy_s) <<< 1;
    num_d[7] = (yz_s + wx_s) <<< 1;
    num_d[8] = (ww_s + zz_s) - (xx_s + yy_s);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      n_q       <= NW'(n_d);
      zero_q[1] <= (n_d == '0);
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        num_q[e] <= num_d[e];
      end
    end
    for (int k = 2; k < NS; k++) begin
      if (en[k]) begin
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  // stages 2 .. NS-1: divider lanes
  logic signed [OUT_WIDTH-1:0] res [NUM_ENTRIES];

  for (genvar e = 0; e < NUM_ENTRIES; e++) begin : g_lane
    qrm_div_lane #(
      .IN_WIDTH  (IN_WIDTH),
      .OUT_WIDTH (OUT_WIDTH)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (en[NS-1:2]),
      .num_i (num_q[e]),
      .den_i (n_q),
      .res_o (res[e])
    );
  end

  logic zero_out;
  assign zero_out = zero_q[NS-1];

  assign out_ch_o.valid     = v_q[NS-1];
  assign out_ch_o.zero_norm = zero_out;
  assign out_ch_o.m00 = zero_out ? '0 : res[0];
  assign out_ch_o.m01 = zero_out ? '0 : res[1];
  assign out_ch_o.m02 = zero_out ? '0 : res[2];
  assign out_ch_o.m10 = zero_out ? '0 : res[3];
  assign out_ch_o.m11 = zero_out ? '0 : res[4];
  assign out_ch_o.m12 = zero_out ? '0 : res[5];
  assign out_ch_o.m20 = zero_out ? '0 : res[6];
  assign out_ch_o.m21 = zero_out ? '0 : res[7];
  assign out_ch_o.m22 = zero_out ? '0 : res[8];

  `QRM_ASSERT_NEXT(a_in_enters, in_ch_i.valid && in_ch_i.ready, v_q[0], "accepted beat lost")
  `QRM_ASSERT_NEXT(a_out_holds, v_q[NS-1] && !out_ch_o.ready, v_q[NS-1], "stalled result dropped")
  `QRM_ASSERT_SAME(a_zero_clear, v_q[NS-1] && zero_out, out_ch_o.m00 == '0 && out_ch_o.m22 == '0, "zero quaternion gave nonzero entry")
  `QRM_ASSERT_SAME(a_range, v_q[NS-1] && !zero_out, out_ch_o.m00 <= LIMIT && out_ch_o.m00 >= -LIMIT && out_ch_o.m11 <= LIMIT && out_ch_o.m11 >= -LIMIT, "diagonal entry out of range")
endmodule
`default_nettype wire

>>> design/qrm_div_lane.sv
// Pipelined restoring divider lane: rounded num * 2^(OUT_WIDTH-2) / den, clamped to +-2^(OUT_WIDTH-2).
`default_nettype none
module qrm_div_lane import qrm_pkg::*; #(
  parameter int unsigned IN_WIDTH  = IN_WIDTH_DEF,
  parameter int unsigned OUT_WIDTH = OUT_WIDTH_DEF,
  localparam int unsigned PW    = 2 * IN_WIDTH,
  localparam int unsigned NW    = PW + 1,
  localparam int unsigned NUMW  = PW + 2,
  localparam int unsigned STEPS = OUT_WIDTH - 1,
  localparam int unsigned LS    = STEPS + 2
) (
  input  wire logic                        clk_i,
  input  wire logic [LS-1:0]               en_i,
  input  wire logic signed [NUMW-1:0]      num_i,
  input  wire logic [NW-1:0]               den_i,
  output logic signed [OUT_WIDTH-1:0]      res_o
);
  localparam int unsigned RW = NW + 1;
  localparam int unsigned QW = STEPS + 1;
  localparam logic [QW-1:0] LIMIT = QW'(1) << (OUT_WIDTH - 2);

  logic [RW-1:0] r_q   [STEPS+1];
  logic [QW-1:0] q_q   [STEPS+1];
  logic [NW-1:0] den_q [STEPS+1];
  logic          neg_q [STEPS+1];
  logic signed [OUT_WIDTH-1:0] res_q;

  logic          neg_d;
  logic [NUMW-1:0] abs_d;
  logic [RW-1:0] mag0_d;

  always_comb begin
    neg_d  = num_i[NUMW-1];
    abs_d  = neg_d ? NUMW'(-num_i) : NUMW'(num_i);
    mag0_d = RW'(abs_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      den_q[0] <= den_i;
      neg_q[0] <= neg_d;
      if (mag0_d >= RW'(den_i)) begin
        r_q[0] <= mag0_d - RW'(den_i);
        q_q[0] <= QW'(1);
      end else begin
        r_q[0] <= mag0_d;
        q_q[0] <= '0;
      end
    end
  end

  for (genvar i = 1; i <= STEPS; i++) begin : g_step
    logic [RW-1:0] t_d;
    logic          ge_d;
    always_comb begin
      t_d  = {r_q[i-1][RW-2:0], 1'b0};
      ge_d = t_d >= RW'(den_q[i-1]);
    end
    always_ff @(posedge clk_i) begin
      if (en_i[i]) begin
        den_q[i] <= den_q[i-1];
        neg_q[i] <= neg_q[i-1];
        r_q[i]   <= ge_d ? (t_d - RW'(den_q[i-1])) : t_d;
        q_q[i]   <= {q_q[i-1][QW-2:0], ge_d};
      end
    end
  end

  logic [QW:0]          qp_d;
  logic [QW-1:0]        mag_d;
  logic [OUT_WIDTH-1:0] res_d;

  always_comb begin
    qp_d  = {1'b0, q_q[STEPS]} + (QW+1)'(1);
    mag_d = qp_d[QW:1];
    if (mag_d > LIMIT) begin
      mag_d = LIMIT;
    end
    res_d = neg_q[STEPS] ? OUT_WIDTH'(-mag_d) : OUT_WIDTH'(mag_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[LS-1]) begin
      res_q <= $signed(res_d);
    end
  end

  assign res_o = res_q;
endmodule
`default_nettype wire
